FILE: hdl/axrot_pkg.sv
// Package for the axis-angle rotation matrix unit: fixed-point widths, CORDIC
// constants, phase scaling constants and the rounding helpers.
// No dependencies; used by hdl/axis_angle_rotation_matrix_unit.sv.
package axrot_pkg;

  // CORDIC working widths (Q2.30 with headroom) and angle width (2^-32 turn)
  localparam int XY_W = 34;
  localparam int Z_W  = 32;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  ang_t;
  typedef logic signed [31:0]     unit_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam int ATAN_LEN = 24;
  localparam ang_t ATAN_TURNS [ATAN_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // CORDIC start value: inverse gain 0.607252935 in Q2.30
  localparam xy_t CORDIC_X0 = 34'sd652032874;

  // 1.0 in Q2.30, wide enough for 1 - cos
  localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

  // round(2^40 / (4*pi^2)) split into low 32 bits and high 3 bits
  localparam logic [31:0] PHASE_K_LO = 32'd2081151113;
  localparam logic [2:0]  PHASE_K_HI = 3'd6;

  // Quadrant codes after folding the phase
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // Square root and divider arrays
  localparam int ISQRT_STAGES = 16;   // two result bits per stage
  localparam int DIV_STAGES   = 16;   // up to two quotient bits per stage
  localparam int DIV_ITERS    = 31;

  // Register map (index taken from paddr[2])
  localparam logic REG_SENS_GAIN = 1'b0;
  localparam logic [15:0] SENS_GAIN_RST = 16'd256;

  localparam logic [15:0] Q14_ONE = 16'd16384;

  // Q2.30 product rounded half up back to Q2.30
  function automatic logic signed [35:0] mul_q30(input logic signed [67:0] prod);
    logic signed [67:0] rnd;
    rnd = (prod + 68'sd536870912) >>> 30;
    mul_q30 = rnd[35:0];
  endfunction

  // Q2.30 to Q2.14, rounded and saturated
  function automatic logic [15:0] to_q14(input logic signed [36:0] v);
    logic signed [36:0] r;
    r = (v + 37'sd32768) >>> 16;
    if (r > 37'sd32767) begin
      to_q14 = 16'h7fff;
    end else if (r < -37'sd32768) begin
      to_q14 = 16'h8000;
    end else begin
      to_q14 = r[15:0];
    end
  endfunction

endpackage

FILE: hdl/axis_angle_rotation_matrix_unit.sv
// Axis-angle rotation matrix unit: top level, fully pipelined.
// Depends on hdl/axrot_pkg.sv.
//
// Each input transfer carries an axis (Q4.12) and an angle amount (Q16.16);
// each output transfer carries the 3x3 rotation block in Q2.14 plus a flag
// for the zero-axis identity case. The unit accepts one transfer per clock
// while the output is not stalled, and its latency is the same for any
// TRIG_STEPS; the latency is set by the axis path (16-stage square root, two
// bits per stage, followed by a 16-stage divider, up to two bits per stage),
// and the angle path (CORDIC, one iteration per stage) is delayed to meet it.
// A stall on the output freezes the whole pipeline. sens_gain is read at the
// first stage, so write it only while the pipeline is empty.
module axis_angle_rotation_matrix_unit #(
  parameter int TRIG_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,    // axis_x, axis_y, axis_z, turn_amount
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [0:0]   out_tuser,   // zero_axis
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int NSTEP = (TRIG_STEPS < axrot_pkg::ATAN_LEN) ? TRIG_STEPS
                                                             : axrot_pkg::ATAN_LEN;
  localparam int LAT_B = 2 + axrot_pkg::ISQRT_STAGES + axrot_pkg::DIV_STAGES + 1;
  localparam int LAT_A = 3 + NSTEP + 1;
  localparam int DLY   = LAT_B - LAT_A;
  localparam int LAT   = LAT_B + 3;

  // ---------------------------------------------------------------- config
  logic [15:0] sens_gain_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == axrot_pkg::REG_SENS_GAIN) ? {16'b0, sens_gain_r}
                                                                  : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_gain_r <= axrot_pkg::SENS_GAIN_RST;
    end else if (cfg_wr && cfg_paddr[2] == axrot_pkg::REG_SENS_GAIN) begin
      sens_gain_r <= cfg_pwdata[15:0];
    end
  end

  // ---------------------------------------------------------------- control
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid | out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // input fields
  logic signed [15:0] in_ax, in_ay, in_az;
  logic signed [31:0] in_turn;

  assign in_ax   = in_tdata[15:0];
  assign in_ay   = in_tdata[31:16];
  assign in_az   = in_tdata[47:32];
  assign in_turn = in_tdata[79:48];

  // ============================================================ angle path
  // stage A1: gain product, Q24.24
  logic signed [48:0] move_nxt;
  logic signed [47:0] a_move_r;

  assign move_nxt = in_turn * $signed({1'b0, sens_gain_r});

  always_ff @(posedge clk) begin
    if (en) begin
      a_move_r <= move_nxt[47:0];
    end
  end

  // stage A2: partial products of move * PHASE_K, bits 32..63 only
  logic [31:0] mv_lo, mv_hi;
  logic [63:0] pll_nxt;
  logic [31:0] a_pll_r, a_plh_r, a_phl_r;

  assign mv_lo   = a_move_r[31:0];
  assign mv_hi   = {{16{a_move_r[47]}}, a_move_r[47:32]};
  assign pll_nxt = 64'(mv_lo) * 64'(axrot_pkg::PHASE_K_LO);

  always_ff @(posedge clk) begin
    if (en) begin
      a_pll_r <= pll_nxt[63:32];
      a_plh_r <= mv_lo * {29'b0, axrot_pkg::PHASE_K_HI};
      a_phl_r <= mv_hi * axrot_pkg::PHASE_K_LO;
    end
  end

  // stage A3: phase, quadrant fold
  logic [31:0]     phase, pfold;
  axrot_pkg::ang_t z0_nxt;

  assign phase  = a_pll_r + a_plh_r + a_phl_r;
  assign pfold  = phase + 32'h2000_0000;
  assign z0_nxt = $signed({2'b00, pfold[29:0]}) - 32'sh2000_0000;

  axrot_pkg::xy_t  cx_r [NSTEP+1];
  axrot_pkg::xy_t  cy_r [NSTEP+1];
  axrot_pkg::ang_t cz_r [NSTEP+1];
  logic [1:0]      cq_r [NSTEP+1];

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= axrot_pkg::CORDIC_X0;
      cy_r[0] <= '0;
      cz_r[0] <= z0_nxt;
      cq_r[0] <= pfold[31:30];
    end
  end

  // CORDIC rotation, one iteration per stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    axrot_pkg::xy_t  dx, dy, x_nxt, y_nxt;
    axrot_pkg::ang_t z_nxt;

    always_comb begin
      dx = cy_r[i] >>> i;
      dy = cx_r[i] >>> i;
      if (!cz_r[i][axrot_pkg::Z_W-1]) begin
        x_nxt = cx_r[i] - dx;
        y_nxt = cy_r[i] + dy;
        z_nxt = cz_r[i] - axrot_pkg::ATAN_TURNS[i];
      end else begin
        x_nxt = cx_r[i] + dx;
        y_nxt = cy_r[i] - dy;
        z_nxt = cz_r[i] + axrot_pkg::ATAN_TURNS[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1] <= x_nxt;
        cy_r[i+1] <= y_nxt;
        cz_r[i+1] <= z_nxt;
        cq_r[i+1] <= cq_r[i];
      end
    end
  end

  // quadrant unfold, then delay to line up with the axis path
  axrot_pkg::xy_t cos_nxt, sin_nxt;
  axrot_pkg::xy_t ac_r [DLY+1];
  axrot_pkg::xy_t as_r [DLY+1];

  always_comb begin
    case (cq_r[NSTEP])
      axrot_pkg::QUAD_I: begin
        cos_nxt = cx_r[NSTEP];
        sin_nxt = cy_r[NSTEP];
      end
      axrot_pkg::QUAD_II: begin
        cos_nxt = -cy_r[NSTEP];
        sin_nxt = cx_r[NSTEP];
      end
      axrot_pkg::QUAD_III: begin
        cos_nxt = -cx_r[NSTEP];
        sin_nxt = -cy_r[NSTEP];
      end
      default: begin
        cos_nxt = cy_r[NSTEP];
        sin_nxt = -cx_r[NSTEP];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r[0] <= cos_nxt;
      as_r[0] <= sin_nxt;
      for (int k = 1; k <= DLY; k++) begin
        ac_r[k] <= ac_r[k-1];
        as_r[k] <= as_r[k-1];
      end
    end
  end

  // ============================================================= axis path
  // stage B1: squares, magnitudes, signs, zero-axis flag
  logic signed [31:0] sqx_nxt, sqy_nxt, sqz_nxt;
  logic [31:0]        b_sq_r [3];
  logic [15:0]        b_mag_r [3];
  logic [2:0]         b_sgn_r;
  logic               b_zero_r;

  assign sqx_nxt = in_ax * in_ax;
  assign sqy_nxt = in_ay * in_ay;
  assign sqz_nxt = in_az * in_az;

  always_ff @(posedge clk) begin
    if (en) begin
      b_sq_r[0]  <= sqx_nxt;
      b_sq_r[1]  <= sqy_nxt;
      b_sq_r[2]  <= sqz_nxt;
      b_mag_r[0] <= in_ax[15] ? 16'(-in_ax) : in_ax;
      b_mag_r[1] <= in_ay[15] ? 16'(-in_ay) : in_ay;
      b_mag_r[2] <= in_az[15] ? 16'(-in_az) : in_az;
      b_sgn_r    <= {in_az[15], in_ay[15], in_ax[15]};
      b_zero_r   <= (in_ax == 16'sd0) && (in_ay == 16'sd0) && (in_az == 16'sd0);
    end
  end

  // stage B2: squared norm
  logic [31:0] n2_r;
  logic [15:0] n_mag_r [3];
  logic [2:0]  n_sgn_r;
  logic        n_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r     <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      n_mag_r  <= b_mag_r;
      n_sgn_r  <= b_sgn_r;
      n_zero_r <= b_zero_r;
    end
  end

  // integer square root of n2 * 2^32, two root bits per stage
  logic [31:0] sr_n2_r   [axrot_pkg::ISQRT_STAGES];
  logic [33:0] sr_rem_r  [axrot_pkg::ISQRT_STAGES];
  logic [31:0] sr_root_r [axrot_pkg::ISQRT_STAGES];
  logic [15:0] sr_mag_r  [axrot_pkg::ISQRT_STAGES][3];
  logic [2:0]  sr_sgn_r  [axrot_pkg::ISQRT_STAGES];
  logic        sr_zero_r [axrot_pkg::ISQRT_STAGES];

  for (genvar s = 0; s < axrot_pkg::ISQRT_STAGES; s++) begin : g_isqrt
    logic [31:0] n2_in, root_in, root_nxt;
    logic [33:0] rem_in, rem_nxt;
    logic [15:0] mag_in [3];
    logic [2:0]  sgn_in;
    logic        zero_in;
    logic [63:0] radicand;
    logic [35:0] r2, trial;

    if (s == 0) begin : g_src
      assign n2_in   = n2_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign mag_in  = n_mag_r;
      assign sgn_in  = n_sgn_r;
      assign zero_in = n_zero_r;
    end else begin : g_src
      assign n2_in   = sr_n2_r[s-1];
      assign rem_in  = sr_rem_r[s-1];
      assign root_in = sr_root_r[s-1];
      assign mag_in  = sr_mag_r[s-1];
      assign sgn_in  = sr_sgn_r[s-1];
      assign zero_in = sr_zero_r[s-1];
    end

    assign radicand = {n2_in, 32'b0};

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      r2       = '0;
      trial    = '0;
      for (int j = 0; j < 2; j++) begin
        r2    = {rem_nxt, radicand[63-2*(2*s+j) -: 2]};
        trial = {2'b00, root_nxt, 2'b01};
        if (r2 >= trial) begin
          rem_nxt  = 34'(r2 - trial);
          root_nxt = {root_nxt[30:0], 1'b1};
        end else begin
          rem_nxt  = r2[33:0];
          root_nxt = {root_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_n2_r[s]   <= n2_in;
        sr_rem_r[s]  <= rem_nxt;
        sr_root_r[s] <= root_nxt;
        sr_mag_r[s]  <= mag_in;
        sr_sgn_r[s]  <= sgn_in;
        sr_zero_r[s] <= zero_in;
      end
    end
  end

  // restoring division: u = round(mag * 2^46 / q), up to two quotient bits per stage
  logic [31:0] dv_q_r    [axrot_pkg::DIV_STAGES];
  logic [31:0] dv_rem_r  [axrot_pkg::DIV_STAGES][3];
  logic [30:0] dv_quo_r  [axrot_pkg::DIV_STAGES][3];
  logic [2:0]  dv_sgn_r  [axrot_pkg::DIV_STAGES];
  logic        dv_zero_r [axrot_pkg::DIV_STAGES];

  for (genvar d = 0; d < axrot_pkg::DIV_STAGES; d++) begin : g_div
    logic [31:0] q_in;
    logic [31:0] rem_in  [3];
    logic [30:0] quo_in  [3];
    logic [31:0] rem_nxt [3];
    logic [30:0] quo_nxt [3];
    logic [2:0]  sgn_in;
    logic        zero_in;
    logic [32:0] r2;

    if (d == 0) begin : g_src
      // remainder starts at mag * 2^15; the bits of q/2 are shifted in
      assign q_in    = sr_root_r[axrot_pkg::ISQRT_STAGES-1];
      assign sgn_in  = sr_sgn_r[axrot_pkg::ISQRT_STAGES-1];
      assign zero_in = sr_zero_r[axrot_pkg::ISQRT_STAGES-1];
      for (genvar c = 0; c < 3; c++) begin : g_comp
        assign rem_in[c] = {1'b0, sr_mag_r[axrot_pkg::ISQRT_STAGES-1][c], 15'b0};
        assign quo_in[c] = '0;
      end
    end else begin : g_src
      assign q_in    = dv_q_r[d-1];
      assign sgn_in  = dv_sgn_r[d-1];
      assign zero_in = dv_zero_r[d-1];
      assign rem_in  = dv_rem_r[d-1];
      assign quo_in  = dv_quo_r[d-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      r2      = '0;
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 2; j++) begin
          if (2*d + j < axrot_pkg::DIV_ITERS) begin
            r2 = {rem_nxt[c], q_in[31-(2*d+j)]};
            if (r2 >= {1'b0, q_in}) begin
              rem_nxt[c] = 32'(r2 - {1'b0, q_in});
              quo_nxt[c] = {quo_nxt[c][29:0], 1'b1};
            end else begin
              rem_nxt[c] = r2[31:0];
              quo_nxt[c] = {quo_nxt[c][29:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q_r[d]    <= q_in;
        dv_rem_r[d]  <= rem_nxt;
        dv_quo_r[d]  <= quo_nxt;
        dv_sgn_r[d]  <= sgn_in;
        dv_zero_r[d] <= zero_in;
      end
    end
  end

  // clamp to 1.0 and apply the sign
  axrot_pkg::unit_t un_r [3];
  logic             un_zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [30:0] mag_c;
        mag_c = (dv_quo_r[axrot_pkg::DIV_STAGES-1][c] > 31'h4000_0000) ? 31'h4000_0000
              : dv_quo_r[axrot_pkg::DIV_STAGES-1][c];
        un_r[c] <= dv_sgn_r[axrot_pkg::DIV_STAGES-1][c] ? -$signed({1'b0, mag_c})
                                                         : $signed({1'b0, mag_c});
      end
      un_zero_r <= dv_zero_r[axrot_pkg::DIV_STAGES-1];
    end
  end

  // ============================================================= Rodrigues
  axrot_pkg::xy_t c_al, s_al;

  assign c_al = ac_r[DLY];
  assign s_al = as_r[DLY];

  // stage R1: u*u^T terms, u*s terms, 1 - c
  logic signed [34:0] t_nxt;
  logic signed [35:0] uu_nxt [6];
  logic signed [35:0] us_nxt [3];
  logic signed [31:0] r1_uu_r [6];   // xx, yy, zz, xy, xz, yz
  logic signed [31:0] r1_us_r [3];   // sx, sy, sz
  logic signed [34:0] r1_t_r;
  axrot_pkg::xy_t     r1_c_r;
  logic               r1_zero_r;

  assign t_nxt     = axrot_pkg::ONE_Q30 - 35'(c_al);
  assign uu_nxt[0] = axrot_pkg::mul_q30(un_r[0] * un_r[0]);
  assign uu_nxt[1] = axrot_pkg::mul_q30(un_r[1] * un_r[1]);
  assign uu_nxt[2] = axrot_pkg::mul_q30(un_r[2] * un_r[2]);
  assign uu_nxt[3] = axrot_pkg::mul_q30(un_r[0] * un_r[1]);
  assign uu_nxt[4] = axrot_pkg::mul_q30(un_r[0] * un_r[2]);
  assign uu_nxt[5] = axrot_pkg::mul_q30(un_r[1] * un_r[2]);
  assign us_nxt[0] = axrot_pkg::mul_q30(un_r[0] * s_al);
  assign us_nxt[1] = axrot_pkg::mul_q30(un_r[1] * s_al);
  assign us_nxt[2] = axrot_pkg::mul_q30(un_r[2] * s_al);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        r1_uu_r[k] <= uu_nxt[k][31:0];
      end
      for (int k = 0; k < 3; k++) begin
        r1_us_r[k] <= us_nxt[k][31:0];
      end
      r1_t_r    <= t_nxt;
      r1_c_r    <= c_al;
      r1_zero_r <= un_zero_r;
    end
  end

  // stage R2: (u*u^T) * (1 - c)
  logic signed [35:0] uut_nxt [6];
  logic signed [35:0] r2_uut_r [6];
  logic signed [31:0] r2_us_r [3];
  axrot_pkg::xy_t     r2_c_r;
  logic               r2_zero_r;

  for (genvar k = 0; k < 6; k++) begin : g_uut
    assign uut_nxt[k] = axrot_pkg::mul_q30(r1_uu_r[k] * r1_t_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_uut_r  <= uut_nxt;
      r2_us_r   <= r1_us_r;
      r2_c_r    <= r1_c_r;
      r2_zero_r <= r1_zero_r;
    end
  end

  // stage R3: entries, rounding to Q2.14, identity on a zero axis
  logic signed [36:0] m_sum [9];
  logic [15:0]        m_r [9];
  logic               zero_r;

  assign m_sum[0] = 37'(r2_c_r) + 37'(r2_uut_r[0]);
  assign m_sum[1] = 37'(r2_uut_r[3]) - 37'(r2_us_r[2]);
  assign m_sum[2] = 37'(r2_uut_r[4]) + 37'(r2_us_r[1]);
  assign m_sum[3] = 37'(r2_uut_r[3]) + 37'(r2_us_r[2]);
  assign m_sum[4] = 37'(r2_c_r) + 37'(r2_uut_r[1]);
  assign m_sum[5] = 37'(r2_uut_r[5]) - 37'(r2_us_r[0]);
  assign m_sum[6] = 37'(r2_uut_r[4]) - 37'(r2_us_r[1]);
  assign m_sum[7] = 37'(r2_uut_r[5]) + 37'(r2_us_r[0]);
  assign m_sum[8] = 37'(r2_c_r) + 37'(r2_uut_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (r2_zero_r) begin
          m_r[k] <= (k % 4 == 0) ? axrot_pkg::Q14_ONE : 16'd0;
        end else begin
          m_r[k] <= axrot_pkg::to_q14(m_sum[k]);
        end
      end
      zero_r <= r2_zero_r;
    end
  end

  assign out_tdata = {m_r[8], m_r[7], m_r[6], m_r[5], m_r[4],
                      m_r[3], m_r[2], m_r[1], m_r[0]};
  assign out_tuser = zero_r;

  // ============================================================ assertions
  // a zero-axis result has ones on the diagonal and a zero m01
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[15:0] == axrot_pkg::Q14_ONE && out_tdata[79:64] == axrot_pkg::Q14_ONE &&
      out_tdata[143:128] == axrot_pkg::Q14_ONE && out_tdata[31:16] == 16'd0)
    else $error("zero axis did not give identity");

  // a stall freezes every valid bit in the pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  // an accepted transfer enters the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transfer lost at entry");

  // normalized components never exceed 1.0 in magnitude
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT_B-1] |->
      un_r[0] <= 32'sh4000_0000 && un_r[0] >= -32'sh4000_0000 &&
      un_r[1] <= 32'sh4000_0000 && un_r[1] >= -32'sh4000_0000 &&
      un_r[2] <= 32'sh4000_0000 && un_r[2] >= -32'sh4000_0000)
    else $error("unit component out of range");

endmodule

FILE: sim/tb_top.sv
// Testbench for the axis-angle rotation matrix unit: random and directed
// rotation requests, sens_gain settings over APB, per-field scoreboard check.
// Depends on hdl/axrot_pkg.sv and hdl/axis_angle_rotation_matrix_unit.sv.

typedef struct {
  logic signed [15:0] m [9];
  logic               zero_axis;
} rot_result_t;

class rot_scoreboard;
  rot_result_t pending_mats [$];
  logic [15:0] gain;
  int          errors;
  int          nsteps;

  function new(int trig_steps);
    gain   = axrot_pkg::SENS_GAIN_RST;
    errors = 0;
    nsteps = (trig_steps < axrot_pkg::ATAN_LEN) ? trig_steps : axrot_pkg::ATAN_LEN;
  endfunction

  static function longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  static function longint mul30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  static function logic [15:0] q14(longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  static function longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  static function longint unit_of(longint v, longint unsigned q);
    longint unsigned mag, u;
    mag = (v < 0) ? -v : v;
    u = ((mag << 46) + (q >> 1)) / q;
    if (u > 64'd1073741824) u = 64'd1073741824;
    return (v < 0) ? -longint'(u) : longint'(u);
  endfunction

  // Predict one rotation matrix from one request
  function void note_request(logic [79:0] d);
    rot_result_t r;
    longint ax, ay, az, turn, x, y, z, dx, dy, c, s, ux, uy, uz, t;
    longint sx, sy, sz;
    longint mm [9];
    longint unsigned mv, q;
    logic [31:0] ph, p;
    logic [1:0] quad;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    turn = longint'($signed(d[79:48]));
    if (ax == 0 && ay == 0 && az == 0) begin
      for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
      r.zero_axis = 1'b1;
      pending_mats.push_back(r);
      return;
    end
    mv = turn * longint'({48'd0, gain});
    mv = mv * 64'd27850954889;
    ph = mv[63:32];
    p = ph + 32'h20000000;
    quad = p[31:30];
    z = longint'({34'd0, p[29:0]}) - 64'sh20000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < nsteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= axrot_pkg::ATAN_TURNS[i];
      end else begin
        x += dx; y -= dy; z += axrot_pkg::ATAN_TURNS[i];
      end
    end
    case (quad)
      axrot_pkg::QUAD_I:   begin c = x;  s = y;  end
      axrot_pkg::QUAD_II:  begin c = -y; s = x;  end
      axrot_pkg::QUAD_III: begin c = -x; s = -y; end
      default:             begin c = y;  s = -x; end
    endcase
    q = root64(longint'(ax * ax + ay * ay + az * az) << 32);
    ux = unit_of(ax, q);
    uy = unit_of(ay, q);
    uz = unit_of(az, q);
    t = 64'sd1073741824 - c;
    sx = mul30(ux, s);
    sy = mul30(uy, s);
    sz = mul30(uz, s);
    mm[0] = c + mul30(mul30(ux, ux), t);
    mm[1] = mul30(mul30(ux, uy), t) - sz;
    mm[2] = mul30(mul30(ux, uz), t) + sy;
    mm[3] = mul30(mul30(uy, ux), t) + sz;
    mm[4] = c + mul30(mul30(uy, uy), t);
    mm[5] = mul30(mul30(uy, uz), t) - sx;
    mm[6] = mul30(mul30(uz, ux), t) - sy;
    mm[7] = mul30(mul30(uz, uy), t) + sx;
    mm[8] = c + mul30(mul30(uz, uz), t);
    for (int i = 0; i < 9; i++) r.m[i] = q14(mm[i]);
    r.zero_axis = 1'b0;
    pending_mats.push_back(r);
  endfunction

  // Compare one output transfer against the oldest prediction
  function void check_matrix(logic [143:0] d, logic zu);
    rot_result_t e;
    if (pending_mats.size() == 0) begin
      $error("unexpected output transfer");
      errors++;
      return;
    end
    e = pending_mats.pop_front();
    for (int i = 0; i < 9; i++) begin
      if (d[16*i +: 16] !== e.m[i]) begin
        $error("m%0d%0d expected %0d actual %0d", i / 3, i % 3, e.m[i],
               $signed(d[16*i +: 16]));
        errors++;
      end
    end
    if (zu !== e.zero_axis) begin
      $error("zero_axis expected %0d actual %0d", e.zero_axis, zu);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int TRIG_STEPS = 16;
  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [79:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  rot_scoreboard sb;
  bit            calm = 1'b0;
  int            cycles = 0;

  axis_angle_rotation_matrix_unit #(.TRIG_STEPS(TRIG_STEPS)) i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, check on each transfer
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_matrix(out_tdata, out_tuser[0]);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_gain(logic [15:0] g);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {axrot_pkg::REG_SENS_GAIN, 2'b00}; cfg_pwdata <= {16'd0, g};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.gain = g;
  endtask

  // Called just after posedge clk; valid stays high into the next request unless a random gap drops it
  task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [31:0] ang);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_request({ang, z, y, x});
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_mats.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mostly small-to-moderate axes, sometimes full-range, single-axis or zero
  task automatic random_request();
    logic [15:0] a [3];
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (kind < 2) a[k] = 16'($urandom);
      else if (kind == 2) a[k] = (k == 0) ? 16'($urandom) : 16'd0;
      else a[k] = 16'($urandom_range(0, 16'h3fff) - 16'sh2000);
    end
    if (kind == 9 && $urandom_range(0, 3) == 0) begin
      a[0] = 0; a[1] = 0; a[2] = 0;
    end
    send_request(a[0], a[1], a[2], $urandom);
  endtask

  initial begin
    sb = new(TRIG_STEPS);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and zero axis with reset gain
    send_request(16'd0, 16'd0, 16'd0, 32'h7fffffff);
    send_request(16'h7fff, 16'h7fff, 16'h7fff, 32'h7fffffff);
    send_request(16'h8000, 16'h8000, 16'h8000, 32'h80000000);
    send_request(16'h8000, 16'd0, 16'd0, 32'h00010000);
    send_request(16'd0, 16'h7fff, 16'd0, 32'h00064880);
    send_request(16'd0, 16'd0, 16'h1000, 32'h00020000);
    send_request(16'd1, 16'd0, 16'd0, 32'h0);
    send_request(16'hffff, 16'h0001, 16'hffff, 32'hffffffff);
    send_request(16'h1000, 16'h1000, 16'h0, 32'h01000000);
    send_request(16'h0, 16'h0, 16'h0, 32'h0);
    drain();
    write_gain(16'hffff);
    send_request(16'h7fff, 16'h8000, 16'h0001, 32'h7fffffff);
    send_request(16'h1000, 16'h0, 16'h0, 32'h80000000);
    send_request(16'h0, 16'h0, 16'h0, 32'h12345678);
    drain();
    write_gain(16'd0);
    send_request(16'h1234, 16'h8000, 16'h7fff, 32'h7fffffff);
    send_request(16'h0, 16'h0, 16'h0, 32'h0);
    drain();

    // Random phases under several gains
    for (int ph = 0; ph < 6; ph++) begin
      write_gain((ph == 0) ? 16'd256 : (ph == 1) ? 16'd1 : 16'($urandom));
      if (ph == 5) calm = 1'b1;
      repeat (180) random_request();
      drain();
    end

    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
